>>> hdl/qlr_pkg.sv
// ----------------------------------------------------------------------------
// qlr_pkg: shared types and constants of the quantised leaky ReLU
// Holds the configuration register indexes, field widths, the stage payload
// structures and the fixed-point constants used by the pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qlr_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned DIFF_W   = SAMPLE_W + 1;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned PROD_W   = 2 * WORD_W;
    localparam int unsigned SHIFT_W  = 6;
    localparam int unsigned SHAMT_W  = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IN_ZP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ZP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MULT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT_MULT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT_SHFT = 3'd5;

    // Fixed-point constants
    localparam logic signed [WORD_W-1:0] Q31_MIN   = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] Q31_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] RND_NUDGE = 64'sh0000_0000_4000_0000;
    localparam logic [SHAMT_W-1:0]       SHAMT_MAX = 5'd31;
    localparam logic signed [WORD_W:0]   ACT_MAX   = 33'sd32767;
    localparam logic signed [WORD_W:0]   ACT_MIN   = -33'sd32768;

    // Item leaving the front end: shifted difference and its path's settings
    typedef struct packed {
        logic signed [WORD_W-1:0] v;
        logic signed [WORD_W-1:0] mult;
        logic [SHAMT_W-1:0]       right;
        logic                     last;
    } front_item_t;

    // Item leaving the multiplier: rounded high word
    typedef struct packed {
        logic signed [WORD_W-1:0] q;
        logic [SHAMT_W-1:0]       right;
        logic                     last;
    } mul_item_t;

endpackage

`default_nettype wire

>>> hdl/qlr_front.sv
// ----------------------------------------------------------------------------
// qlr_front: zero point subtraction, path selection and left shift
// Two register stages: the first forms the difference and picks the
// multiplier and shift amounts, the second applies the wrapping left shift.
// ----------------------------------------------------------------------------
`default_nettype none

module qlr_front (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic signed [qlr_pkg::SAMPLE_W-1:0]    in_zero_point,
    input  wire logic signed [qlr_pkg::WORD_W-1:0]      alpha_multiplier,
    input  wire logic signed [qlr_pkg::SHIFT_W-1:0]     alpha_shift,
    input  wire logic signed [qlr_pkg::WORD_W-1:0]      identity_multiplier,
    input  wire logic signed [qlr_pkg::SHIFT_W-1:0]     identity_shift,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [qlr_pkg::SAMPLE_W-1:0]    in_sample,
    input  wire logic                                   in_last,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output qlr_pkg::front_item_t                        out_item
);

    logic                                   v1_reg;
    logic                                   v2_reg;
    logic                                   rdy1;
    logic                                   rdy2;
    logic signed [qlr_pkg::DIFF_W-1:0]      diff;
    logic signed [qlr_pkg::SHIFT_W-1:0]     shift_sel;
    logic [qlr_pkg::SHIFT_W-1:0]            shift_neg;
    logic signed [qlr_pkg::DIFF_W-1:0]      d_reg;
    logic signed [qlr_pkg::WORD_W-1:0]      mult_reg;
    logic [qlr_pkg::SHAMT_W-1:0]            left_reg;
    logic [qlr_pkg::SHAMT_W-1:0]            right_reg;
    logic                                   last1_reg;
    logic [qlr_pkg::SHAMT_W-1:0]            left_next;
    logic [qlr_pkg::SHAMT_W-1:0]            right_next;
    logic signed [qlr_pkg::WORD_W-1:0]      d_wide;
    qlr_pkg::front_item_t                   item_reg;
    qlr_pkg::front_item_t                   item_next;

    // A stage takes a new item when it is empty or its item moves on.
    assign rdy2      = !v2_reg || out_ready;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v2_reg;
    assign out_item  = item_reg;

    // Difference and choice of path; a negative difference takes alpha.
    always_comb begin
        diff      = qlr_pkg::DIFF_W'(in_sample) - qlr_pkg::DIFF_W'(in_zero_point);
        shift_sel = diff[qlr_pkg::DIFF_W-1] ? alpha_shift : identity_shift;
        shift_neg = -shift_sel;
        if (shift_sel[qlr_pkg::SHIFT_W-1]) begin
            left_next  = '0;
            right_next = shift_neg[qlr_pkg::SHIFT_W-1] ? qlr_pkg::SHAMT_MAX
                                                        : shift_neg[qlr_pkg::SHAMT_W-1:0];
        end else begin
            left_next  = shift_sel[qlr_pkg::SHAMT_W-1:0];
            right_next = '0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (in_valid && rdy1) begin
            d_reg     <= diff;
            mult_reg  <= diff[qlr_pkg::DIFF_W-1] ? alpha_multiplier : identity_multiplier;
            left_reg  <= left_next;
            right_reg <= right_next;
            last1_reg <= in_last;
        end
    end

    // Left shift with wrap to 32 bits.
    always_comb begin
        d_wide          = qlr_pkg::WORD_W'(d_reg);
        item_next.v     = d_wide << left_reg;
        item_next.mult  = mult_reg;
        item_next.right = right_reg;
        item_next.last  = last1_reg;
    end

    // Stage 2 payload
    always_ff @(posedge aclk) begin
        if (v1_reg && rdy2) begin
            item_reg <= item_next;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // A negative difference must carry the alpha multiplier.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && rdy1 && diff[qlr_pkg::DIFF_W-1]) |=> (mult_reg == $past(alpha_multiplier)))
        else $error("negative difference did not select the alpha multiplier");

endmodule

`default_nettype wire

>>> hdl/qlr_mul.sv
// ----------------------------------------------------------------------------
// qlr_mul: rounding doubling high multiply
// Two register stages: a 32 by 32 signed product, then the rounding nudge,
// the division by 2^31 and saturation of the single overflow case.
// ----------------------------------------------------------------------------
`default_nettype none

module qlr_mul (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire qlr_pkg::front_item_t   in_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output qlr_pkg::mul_item_t          out_item
);

    logic                                   v3_reg;
    logic                                   v4_reg;
    logic                                   rdy3;
    logic                                   rdy4;
    logic signed [qlr_pkg::PROD_W-1:0]      prod_next;
    logic signed [qlr_pkg::PROD_W-1:0]      prod_reg;
    logic                                   sat_reg;
    logic [qlr_pkg::SHAMT_W-1:0]            right3_reg;
    logic                                   last3_reg;
    logic signed [qlr_pkg::PROD_W-1:0]      rnd_sum;
    qlr_pkg::mul_item_t                     item_reg;
    qlr_pkg::mul_item_t                     item_next;

    assign rdy4      = !v4_reg || out_ready;
    assign rdy3      = !v3_reg || rdy4;
    assign in_ready  = rdy3;
    assign out_valid = v4_reg;
    assign out_item  = item_reg;

    assign prod_next = in_item.v * in_item.mult;

    // Stage 3: product, and a flag for both operands at the most negative value.
    always_ff @(posedge aclk) begin
        if (in_valid && rdy3) begin
            prod_reg   <= prod_next;
            sat_reg    <= (in_item.v == qlr_pkg::Q31_MIN) && (in_item.mult == qlr_pkg::Q31_MIN);
            right3_reg <= in_item.right;
            last3_reg  <= in_item.last;
        end
    end

    // With a nudge of 2^30 the truncating division by 2^31 becomes an
    // arithmetic shift for either sign of the product.
    always_comb begin
        rnd_sum         = prod_reg + qlr_pkg::RND_NUDGE;
        item_next.q     = sat_reg ? qlr_pkg::Q31_MAX : rnd_sum[62:31];
        item_next.right = right3_reg;
        item_next.last  = last3_reg;
    end

    // Stage 4 payload
    always_ff @(posedge aclk) begin
        if (v3_reg && rdy4) begin
            item_reg <= item_next;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy3) begin
                v3_reg <= in_valid;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // The overflow case must leave the largest positive value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && rdy4 && sat_reg) |=> (item_reg.q == qlr_pkg::Q31_MAX))
        else $error("saturated multiply did not give the largest positive value");

endmodule

`default_nettype wire

>>> hdl/qlr_back.sv
// ----------------------------------------------------------------------------
// qlr_back: right shift, output zero point and clamp
// Two register stages: an arithmetic right shift, then the zero point
// addition and the clamp to the signed 16-bit range in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qlr_back (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic signed [qlr_pkg::SAMPLE_W-1:0]    out_zero_point,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire qlr_pkg::mul_item_t                     in_item,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [qlr_pkg::SAMPLE_W-1:0]         out_activation,
    output logic                                        out_last
);

    logic                                   v5_reg;
    logic                                   v6_reg;
    logic                                   rdy5;
    logic                                   rdy6;
    logic signed [qlr_pkg::WORD_W-1:0]      sh_reg;
    logic                                   last5_reg;
    logic signed [qlr_pkg::WORD_W:0]        sum;
    logic signed [qlr_pkg::SAMPLE_W-1:0]    act_next;
    logic signed [qlr_pkg::SAMPLE_W-1:0]    act_reg;
    logic                                   last6_reg;

    assign rdy6           = !v6_reg || out_ready;
    assign rdy5           = !v5_reg || rdy6;
    assign in_ready       = rdy5;
    assign out_valid      = v6_reg;
    assign out_activation = act_reg;
    assign out_last       = last6_reg;

    // Stage 5: arithmetic right shift, truncating toward minus infinity.
    always_ff @(posedge aclk) begin
        if (in_valid && rdy5) begin
            sh_reg    <= in_item.q >>> in_item.right;
            last5_reg <= in_item.last;
        end
    end

    // Zero point is added at full width and only the clamp bounds the sum.
    always_comb begin
        sum = (qlr_pkg::WORD_W + 1)'(sh_reg) + (qlr_pkg::WORD_W + 1)'(out_zero_point);
        if (sum > qlr_pkg::ACT_MAX) begin
            act_next = qlr_pkg::SAMPLE_W'(qlr_pkg::ACT_MAX);
        end else if (sum < qlr_pkg::ACT_MIN) begin
            act_next = qlr_pkg::SAMPLE_W'(qlr_pkg::ACT_MIN);
        end else begin
            act_next = sum[qlr_pkg::SAMPLE_W-1:0];
        end
    end

    // Stage 6: output register
    always_ff @(posedge aclk) begin
        if (v5_reg && rdy6) begin
            act_reg   <= act_next;
            last6_reg <= last5_reg;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy5) begin
                v5_reg <= in_valid;
            end
            if (rdy6) begin
                v6_reg <= v5_reg;
            end
        end
    end

    // With no right shift the high word passes unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && rdy5 && (in_item.right == '0)) |=> (sh_reg == $past(in_item.q)))
        else $error("zero right shift altered the value");

endmodule

`default_nettype wire

>>> hdl/quantized_leaky_relu_s16.sv
// Quantised int16 leaky ReLU. Each signed 16-bit sample has the input zero
// point removed; a non-negative difference is scaled by the identity
// multiplier and shift, a negative one by the alpha multiplier and shift,
// each as a wrapping left shift, a rounding doubling high multiply and an
// arithmetic right shift; the output zero point is then added and the
// result clamped to int16. It takes one item per clock unless stalled and
// returns one result per item through a six-stage pipeline whose deepest
// stage is the 32 by 32 bit multiplier; every stage has its own valid bit,
// so bubbles close up while the output is held. Write the configuration
// registers through the cfg port only while no item is in flight; the block
// does not enforce it. Unknown indexes are ignored; cfg_ready is always high.
// ----------------------------------------------------------------------------
// quantized_leaky_relu_s16: top level of the quantised leaky ReLU
// Configuration registers and the chain of front end, multiplier and back
// end pipeline segments.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_leaky_relu_s16 (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [qlr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [qlr_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input items
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [qlr_pkg::SAMPLE_W-1:0]       s_tdata,   // [15:0] sample
    input  wire logic                               s_tlast,
    // Result items
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [qlr_pkg::SAMPLE_W-1:0]            m_tdata,   // [15:0] activation
    output logic                                    m_tlast
);

    logic signed [qlr_pkg::SAMPLE_W-1:0]    in_zp_reg;
    logic signed [qlr_pkg::SAMPLE_W-1:0]    out_zp_reg;
    logic signed [qlr_pkg::WORD_W-1:0]      alpha_mult_reg;
    logic signed [qlr_pkg::SHIFT_W-1:0]     alpha_shift_reg;
    logic signed [qlr_pkg::WORD_W-1:0]      ident_mult_reg;
    logic signed [qlr_pkg::SHIFT_W-1:0]     ident_shift_reg;

    logic                                   front_valid;
    logic                                   front_ready;
    qlr_pkg::front_item_t                   front_item;
    logic                                   mul_valid;
    logic                                   mul_ready;
    qlr_pkg::mul_item_t                     mul_item;
    logic signed [qlr_pkg::SAMPLE_W-1:0]    activation;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_zp_reg       <= '0;
            out_zp_reg      <= '0;
            alpha_mult_reg  <= '0;
            alpha_shift_reg <= '0;
            ident_mult_reg  <= '0;
            ident_shift_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                qlr_pkg::CFG_IN_ZP:      in_zp_reg       <= cfg_data[qlr_pkg::SAMPLE_W-1:0];
                qlr_pkg::CFG_OUT_ZP:     out_zp_reg      <= cfg_data[qlr_pkg::SAMPLE_W-1:0];
                qlr_pkg::CFG_ALPHA_MULT: alpha_mult_reg  <= cfg_data[qlr_pkg::WORD_W-1:0];
                qlr_pkg::CFG_ALPHA_SHFT: alpha_shift_reg <= cfg_data[qlr_pkg::SHIFT_W-1:0];
                qlr_pkg::CFG_IDENT_MULT: ident_mult_reg  <= cfg_data[qlr_pkg::WORD_W-1:0];
                qlr_pkg::CFG_IDENT_SHFT: ident_shift_reg <= cfg_data[qlr_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Stages 1 and 2
    qlr_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_zero_point       (in_zp_reg),
        .alpha_multiplier    (alpha_mult_reg),
        .alpha_shift         (alpha_shift_reg),
        .identity_multiplier (ident_mult_reg),
        .identity_shift      (ident_shift_reg),
        .in_valid            (s_tvalid),
        .in_ready            (s_tready),
        .in_sample           (s_tdata),
        .in_last             (s_tlast),
        .out_valid           (front_valid),
        .out_ready           (front_ready),
        .out_item            (front_item)
    );

    // Stages 3 and 4
    qlr_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_item  (mul_item)
    );

    // Stages 5 and 6
    qlr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .out_zero_point (out_zp_reg),
        .in_valid       (mul_valid),
        .in_ready       (mul_ready),
        .in_item        (mul_item),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_activation (activation),
        .out_last       (m_tlast)
    );

    assign m_tdata = activation;

    // A write to a shift register must keep exactly its low six bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && (cfg_index == qlr_pkg::CFG_ALPHA_SHFT))
        |=> (alpha_shift_reg == $past(cfg_data[qlr_pkg::SHIFT_W-1:0])))
        else $error("alpha shift register write lost");

    // The output zero point only changes through its own register index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!cfg_valid || (cfg_index != qlr_pkg::CFG_OUT_ZP)) |=> $stable(out_zp_reg))
        else $error("output zero point changed without a write");

endmodule

`default_nettype wire

>>> sim/quantized_leaky_relu_s16_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_leaky_relu_s16_tb: self-checking bench for the int16 leaky ReLU
// A short table of directed items and register writes is followed by random
// phases, each with its own register setting. Every accepted sample is scored
// against its expected value from the table or a local model of the scaling
// path, and each returned item is compared in order with the oldest
// prediction, under random input bursts and output stalls.
// ----------------------------------------------------------------------------

module quantized_leaky_relu_s16_tb;

    // Indexes that no register answers to
    localparam logic [qlr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [qlr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int N_PHASES      = 16;
    localparam int ITEMS_PER_PHS = 64;
    localparam int N_ROWS        = 26;
    localparam int MAX_REPORTS   = 20;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef enum logic [1:0] {
        READY_ALWAYS, READY_COIN, READY_EVERY_FOURTH, READY_SPARSE
    } stall_mode_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [qlr_pkg::CFG_IDX_W-1:0]  idx;
        logic [31:0]                    data;   // register value, or sample in [15:0]
        logic                           last;
        logic                           typed;  // want holds the result to expect
        logic [qlr_pkg::SAMPLE_W-1:0]   want;
    } stim_row_t;

    typedef struct packed {
        logic [qlr_pkg::SAMPLE_W-1:0] act;
        logic                         last;
    } act_item_t;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [qlr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [qlr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [qlr_pkg::SAMPLE_W-1:0]   s_tdata   = '0;   // [15:0] sample
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [qlr_pkg::SAMPLE_W-1:0]   m_tdata;          // [15:0] activation
    logic                           m_tlast;

    // Local copy of the register file
    logic signed [15:0] zp_in    = '0;
    logic signed [15:0] zp_out   = '0;
    logic signed [31:0] neg_mult = '0;
    logic signed [5:0]  neg_shift = '0;
    logic signed [31:0] pos_mult = '0;
    logic signed [5:0]  pos_shift = '0;

    act_item_t   pending_acts[$];
    act_item_t   oldest;
    int          err_count   = 0;
    int          items_sent  = 0;
    int          neg_items   = 0;
    int          results_seen = 0;
    int          cfg_writes  = 0;
    int          burst_left  = 0;
    stall_mode_t ready_mode  = READY_ALWAYS;
    int          ready_count = 0;

    // Directed rows: reset values, saturation, wrap, extreme zero points
    stim_row_t directed_rows [N_ROWS] = '{
        '{ROW_ITEM, '0,                      32'h0000_7FFF, 1'b0, 1'b1, 16'h0000},
        '{ROW_ITEM, '0,                      32'h0000_8000, 1'b1, 1'b1, 16'h0000},
        '{ROW_ITEM, '0,                      32'h0000_0001, 1'b0, 1'b1, 16'h0000},
        '{ROW_CFG,  qlr_pkg::CFG_IDENT_MULT, 32'h8000_0000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG,  qlr_pkg::CFG_IDENT_SHFT, 32'h0000_001F, 1'b0, 1'b0, 16'h0000},
        '{ROW_ITEM, '0,                      32'h0000_0001, 1'b0, 1'b1, 16'h7FFF},
        '{ROW_ITEM, '0,                      32'h0000_0003, 1'b1, 1'b1, 16'h7FFF},
        '{ROW_ITEM, '0,                      32'h0000_0002, 1'b0, 1'b1, 16'h0000},
        '{ROW_CFG,  qlr_pkg::CFG_ALPHA_MULT, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG,  qlr_pkg::CFG_ALPHA_SHFT, 32'h0000_0020, 1'b0, 1'b0, 16'h0000},
        '{ROW_ITEM, '0,                      32'h0000_8000, 1'b1, 1'b0, 16'h0000},
        '{ROW_ITEM, '0,                      32'h0000_FFFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG,  qlr_pkg::CFG_IN_ZP,      32'h0000_7FFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG,  qlr_pkg::CFG_OUT_ZP,     32'hFFFF_8000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG,  CFG_SPARE_LO,            32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG,  CFG_SPARE_HI,            32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_ITEM, '0,                      32'h0000_8000, 1'b0, 1'b0, 16'h0000},
        '{ROW_ITEM, '0,                      32'h0000_7FFF, 1'b1, 1'b0, 16'h0000},
        '{ROW_ITEM, '0,                      32'h0000_7FFE, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG,  qlr_pkg::CFG_IN_ZP,      32'hFFFF_8000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG,  qlr_pkg::CFG_OUT_ZP,     32'h0000_7FFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG,  qlr_pkg::CFG_IDENT_SHFT, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
        '{ROW_CFG,  qlr_pkg::CFG_IDENT_MULT, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'h0000},
        '{ROW_ITEM, '0,                      32'h0000_7FFF, 1'b0, 1'b1, 16'h7FFF},
        '{ROW_ITEM, '0,                      32'h0000_8000, 1'b1, 1'b0, 16'h0000},
        '{ROW_ITEM, '0,                      32'h0000_0000, 1'b1, 1'b0, 16'h0000}
    };

    quantized_leaky_relu_s16 uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Scales one sample the way the block should: zero point removal, path
    // choice, wrapping left shift, rounding doubling high multiply with its
    // single saturating case, arithmetic right shift, offset and clamp.
    function automatic logic [qlr_pkg::SAMPLE_W-1:0] activation_of(
            input logic signed [15:0] x);
        int     d, v, mult, shamt, left, right;
        longint prod, sum;
        d = int'(x) - int'(zp_in);
        if (d >= 0) begin
            mult  = pos_mult;
            shamt = int'(pos_shift);
        end else begin
            mult  = neg_mult;
            shamt = int'(neg_shift);
        end
        left  = (shamt > 0) ? shamt : 0;
        right = (shamt < 0) ? -shamt : 0;
        if (right > 31) right = 31;
        v = d << left;
        if (v == int'(32'h8000_0000) && mult == int'(32'h8000_0000)) begin
            v = int'(32'h7FFF_FFFF);
        end else begin
            prod = longint'(v) * longint'(mult);
            prod = prod + ((prod >= 0) ? (longint'(1) << 30)
                                       : (longint'(1) - (longint'(1) << 30)));
            v = int'(prod / (longint'(1) << 31));
        end
        v = v >>> right;
        sum = longint'(v) + longint'(zp_out);
        if (sum < -32768) sum = -32768;
        if (sum > 32767) sum = 32767;
        return sum[15:0];
    endfunction

    // Sign-extends a narrow register value, sometimes with junk above it.
    function automatic logic [31:0] widen(input logic [31:0] v, input int w);
        logic [31:0] r, mask;
        mask = 32'hFFFF_FFFF << w;
        r = v & ~mask;
        if (r[w-1]) r = r | mask;
        if ($urandom_range(0, 3) == 0) r = (r & ~mask) | ($urandom() & mask);
        return r;
    endfunction

    function automatic logic [31:0] pick_mult();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return $urandom();
            default: return $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
        endcase
    endfunction

    function automatic logic [5:0] pick_shift();
        case ($urandom_range(0, 7))
            0: return 6'h20;
            1: return 6'h1F;
            2: return 6'h21;
            3: return 6'($urandom());
            default: return 6'(int'($urandom_range(0, 9)) - 6);
        endcase
    endfunction

    function automatic logic [15:0] pick_zp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom());
            default: return 16'(int'($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    // Samples cluster around the input zero point so both paths see real work
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            1, 2: return 16'($urandom());
            default: return 16'(int'(zp_in) + int'($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want_v);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t ns: %s: got %0d, expected %0d",
                     $time, what, $signed(got), $signed(want_v));
    endtask

    // Writes one register once the pipeline has drained, and mirrors it.
    task automatic write_reg(input logic [qlr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        s_tvalid <= 1'b0;
        while (pending_acts.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
        case (idx)
            qlr_pkg::CFG_IN_ZP:      zp_in     = val[15:0];
            qlr_pkg::CFG_OUT_ZP:     zp_out    = val[15:0];
            qlr_pkg::CFG_ALPHA_MULT: neg_mult  = val;
            qlr_pkg::CFG_ALPHA_SHFT: neg_shift = val[5:0];
            qlr_pkg::CFG_IDENT_MULT: pos_mult  = val;
            qlr_pkg::CFG_IDENT_SHFT: pos_shift = val[5:0];
            default: ;
        endcase
    endtask

    task automatic load_setup(input logic [15:0] izp, input logic [15:0] ozp,
                              input logic [31:0] am, input logic [5:0] ash,
                              input logic [31:0] im, input logic [5:0] ish);
        write_reg(qlr_pkg::CFG_IN_ZP,      widen(32'(izp), qlr_pkg::SAMPLE_W));
        write_reg(qlr_pkg::CFG_OUT_ZP,     widen(32'(ozp), qlr_pkg::SAMPLE_W));
        write_reg(qlr_pkg::CFG_ALPHA_MULT, am);
        write_reg(qlr_pkg::CFG_ALPHA_SHFT, widen(32'(ash), qlr_pkg::SHIFT_W));
        write_reg(qlr_pkg::CFG_IDENT_MULT, im);
        write_reg(qlr_pkg::CFG_IDENT_SHFT, widen(32'(ish), qlr_pkg::SHIFT_W));
    endtask

    // Offers one sample inside a random burst and records what should return.
    task automatic send_sample(input logic [15:0] x, input logic l,
                               input logic typed, input logic [15:0] want_v);
        int gap;
        cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (int'($signed(x)) - int'(zp_in) < 0) neg_items++;
        pending_acts.push_back('{typed ? want_v : activation_of(x), l});
    endtask

    // Output back-pressure: a mode is held for a random stretch of cycles.
    always @(posedge aclk) begin
        if (ready_count == 0) begin
            ready_mode  <= stall_mode_t'($urandom_range(0, 3));
            ready_count <= $urandom_range(20, 120);
        end else begin
            ready_count <= ready_count - 1;
        end
        case (ready_mode)
            READY_ALWAYS:       m_tready <= 1'b1;
            READY_COIN:         m_tready <= 1'($urandom_range(0, 1));
            READY_EVERY_FOURTH: m_tready <= (ready_count % 4 == 0);
            default:            m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Each returned item is compared with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_acts.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata, '0);
            end else begin
                oldest = pending_acts.pop_front();
                if (m_tdata !== oldest.act)
                    report_mismatch("activation", m_tdata, oldest.act);
                if (m_tlast !== oldest.last)
                    report_mismatch("last flag", 16'(m_tlast), 16'(oldest.last));
            end
        end
    end

    // Stimulus: directed table first, then random phases.
    initial begin
        stim_row_t row;
        int        phase, n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG)
                write_reg(row.idx, row.data);
            else
                send_sample(row.data[15:0], row.last, row.typed, row.want);
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            if (phase == 0)
                load_setup(16'h8000, 16'h8000, 32'h8000_0000, 6'h20,
                           32'h8000_0000, 6'h20);
            else if (phase == 1)
                load_setup(16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 6'h1F,
                           32'h7FFF_FFFF, 6'h1F);
            else
                load_setup(pick_zp(), pick_zp(), pick_mult(), pick_shift(),
                           pick_mult(), pick_shift());
            for (n = 0; n < ITEMS_PER_PHS; n++)
                send_sample(pick_sample(), ($urandom_range(0, 7) == 0), 1'b0, '0);
        end

        // Drain the pipeline, then keep watching for stray items.
        s_tvalid <= 1'b0;
        while (pending_acts.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d samples (%0d on the negative slope) under %0d register writes;",
                 items_sent, neg_items, cfg_writes);
        $display("received %0d results, %0d mismatches.", results_seen, err_count);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog for a stalled handshake.
    initial begin
        #2_000_000;
        $display("Timed out with %0d results still pending.", pending_acts.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
